// ===== hdl/mm_pkg.sv =====
// Shared types and constants for the matrix multiply block.
// Used by matrix_multiply and mm_mac; depends on nothing else.
package mm_pkg;

	localparam int DIM_W = 4;   // size registers
	localparam int IDX_W = 3;   // row and column indexes
	localparam int ACT_W = 2;   // action code
	localparam int OUT_W = 21;  // rounded product element
	localparam int CFG_W = 2;   // register index

	localparam logic [ACT_W-1:0] ACT_LOAD_A = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LOAD_B = 2'd1;
	localparam logic [ACT_W-1:0] ACT_START  = 2'd2;

	localparam logic [CFG_W-1:0] CFG_ROWS_A     = 2'd0;
	localparam logic [CFG_W-1:0] CFG_INNER_SIZE = 2'd1;
	localparam logic [CFG_W-1:0] CFG_COLS_B     = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_CALC   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	typedef struct packed {
		logic clear;
		logic valid;
	} mac_ctrl_t;

endpackage

// ===== hdl/mm_mac.sv =====
// Shared multiply-accumulate unit with round-to-nearest output.
// Depends on mm_pkg for the control struct and the output width.
module mm_mac
	import mm_pkg::*;
#(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16,
	parameter int FRAC_BITS  = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mac_ctrl_t                    ctrl,
	input  logic signed [ELEM_WIDTH-1:0] a,
	input  logic signed [ELEM_WIDTH-1:0] b,
	output logic                         busy,
	output logic        [OUT_W-1:0]      result
);

	localparam int PROD_W = 2 * ELEM_WIDTH;
	localparam int SUM_W  = PROD_W + $clog2(MAX_DIM) + 1;
	localparam int MIN_W  = FRAC_BITS + OUT_W + 1;
	localparam int ACC_W  = (SUM_W > MIN_W) ? SUM_W : MIN_W;
	localparam logic [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

	logic signed [PROD_W-1:0] prod_s2;
	logic                     vld_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic        [ACC_W-1:0]  rounded;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a * b;
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Adding one half and keeping the upper bits rounds ties upward.
	assign rounded = acc_q + HALF;
	assign result  = rounded[FRAC_BITS +: OUT_W];
	assign busy    = vld_s2;

endmodule

// ===== hdl/matrix_multiply.sv =====
// Top level of the matrix multiply block: element stores, sequencer, output register.
// Depends on mm_pkg and mm_mac.
//
//  channel  | signals                                       | transfer
//  ---------+-----------------------------------------------+---------------------
//  input    | in_valid/in_ready, action, row_index,         | valid and ready high
//           | col_index, element_value                      |
//  output   | out_valid/out_ready, out_row, out_col,        | valid and ready high
//           | out_value, last                               |
//  config   | cfg_we, cfg_addr, cfg_wdata                   | cfg_we high
//
// Loads are accepted back to back while the block is idle.
// A start computes rows_a * cols_b product elements and can stall on the output: each
// product element runs inner_size reads through one read port per store and the
// single multiply-accumulate unit, then drains the pipeline and registers it.
// The output register lets the next element compute while one waits to be taken.
// Reset sets all sizes to MAX_DIM; the element stores hold no reset value.
module matrix_multiply
	import mm_pkg::*;
#(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16,
	parameter int FRAC_BITS  = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic        [CFG_W-1:0]      cfg_addr,
	input  logic        [DIM_W-1:0]      cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic        [ACT_W-1:0]      action,
	input  logic        [IDX_W-1:0]      row_index,
	input  logic        [IDX_W-1:0]      col_index,
	input  logic signed [ELEM_WIDTH-1:0] element_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic        [IDX_W-1:0]      out_row,
	output logic        [IDX_W-1:0]      out_col,
	output logic signed [OUT_W-1:0]      out_value,
	output logic                         last
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
	                                                input logic [IDX_W-1:0] col);
		return ADDR_W'(int'(row) * MAX_DIM + int'(col));
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		if (v == '0)
			return DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			return DIM_W'(MAX_DIM);
		else
			return v;
	endfunction

	logic [DIM_W-1:0] rows_a_q, inner_q, cols_b_q;
	state_t           state_q;
	logic [IDX_W-1:0] r_q, c_q, k_q;
	logic             vld_s1;
	logic             out_valid_q;

	logic signed [ELEM_WIDTH-1:0] mem_a [DEPTH];
	logic signed [ELEM_WIDTH-1:0] mem_b [DEPTH];
	logic signed [ELEM_WIDTH-1:0] a_rd_s1, b_rd_s1;

	logic in_fire, start, wr_a, wr_b;
	logic k_last, c_last, r_last;
	logic pipe_empty, push;
	logic mac_busy;
	logic [OUT_W-1:0] mac_result;
	mac_ctrl_t mac_ctrl;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		wr_a  = 1'b0;
		wr_b  = 1'b0;
		start = 1'b0;
		unique case (action)
			ACT_LOAD_A: wr_a  = in_fire && (DIM_W'(row_index) < rows_a_q)
			                            && (DIM_W'(col_index) < inner_q);
			ACT_LOAD_B: wr_b  = in_fire && (DIM_W'(row_index) < inner_q)
			                            && (DIM_W'(col_index) < cols_b_q);
			ACT_START:  start = in_fire;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= DIM_W'(MAX_DIM);
			inner_q  <= DIM_W'(MAX_DIM);
			cols_b_q <= DIM_W'(MAX_DIM);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_ROWS_A:     rows_a_q <= clamp_dim(cfg_wdata);
				CFG_INNER_SIZE: inner_q  <= clamp_dim(cfg_wdata);
				CFG_COLS_B:     cols_b_q <= clamp_dim(cfg_wdata);
				default: ;
			endcase
		end
	end

	// A is read along its row, B down its column.
	always_ff @(posedge clk) begin
		if (wr_a)
			mem_a[elem_addr(row_index, col_index)] <= element_value;
		a_rd_s1 <= mem_a[elem_addr(r_q, k_q)];
	end

	always_ff @(posedge clk) begin
		if (wr_b)
			mem_b[elem_addr(row_index, col_index)] <= element_value;
		b_rd_s1 <= mem_b[elem_addr(k_q, c_q)];
	end

	assign k_last     = (DIM_W'(k_q) + DIM_W'(1)) == inner_q;
	assign c_last     = (DIM_W'(c_q) + DIM_W'(1)) == cols_b_q;
	assign r_last     = (DIM_W'(r_q) + DIM_W'(1)) == rows_a_q;
	assign pipe_empty = !vld_s1 && !mac_busy;
	assign push       = (state_q == ST_FINISH) && pipe_empty && (!out_valid_q || out_ready);

	assign mac_ctrl.clear = start || (push && !(c_last && r_last));
	assign mac_ctrl.valid = vld_s1;

	mm_mac #(
		.MAX_DIM   (MAX_DIM),
		.ELEM_WIDTH(ELEM_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (mac_ctrl),
		.a     (a_rd_s1),
		.b     (b_rd_s1),
		.busy  (mac_busy),
		.result(mac_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			r_q         <= '0;
			c_q         <= '0;
			k_q         <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_CALC);

			if (push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						r_q     <= '0;
						c_q     <= '0;
						k_q     <= '0;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (k_last) begin
						k_q     <= '0;
						state_q <= ST_FINISH;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				ST_FINISH: begin
					if (push) begin
						if (c_last) begin
							c_q <= '0;
							if (r_last) begin
								state_q <= ST_IDLE;
							end else begin
								r_q     <= r_q + IDX_W'(1);
								state_q <= ST_CALC;
							end
						end else begin
							c_q     <= c_q + IDX_W'(1);
							state_q <= ST_CALC;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_row   <= r_q;
			out_col   <= c_q;
			out_value <= mac_result;
			last      <= c_last && r_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule
